@@ hw/rtl/hse_pkg.sv @@
package hse_pkg;

   // input transaction payload
   typedef struct packed {
      logic signed [31:0] value;
      logic               final_item;
   } req_type;

   // result transaction payload
   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               end_of_run;
      logic               overflowed;
   } rsp_type;

   // controller states
   typedef enum logic [3:0] {
      S_LOAD,
      S_SETUP,
      S_ROOT_RD,
      S_ROOT_LD,
      S_CHILD_RD,
      S_SIFT,
      S_BUILD_NEXT,
      S_EXT_RD,
      S_EXT_LD,
      S_EXT_NEXT,
      S_OUT_RD,
      S_OUT_LD,
      S_OUT_WAIT
   } state_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SETUP,
      OP_ROOT_RD,
      OP_ROOT_LD,
      OP_CHILD_RD,
      OP_SIFT,
      OP_BUILD_NEXT,
      OP_EXT_RD,
      OP_EXT_LD,
      OP_EXT_NEXT,
      OP_OUT_RD,
      OP_OUT_LD,
      OP_OUT_NEXT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic req_final;   // final_item of the pending input transaction
      logic short_set;   // fewer than two stored elements
      logic sift_more;   // a child is larger than the sifted element
      logic i_one;       // loop index has reached one
      logic out_last;    // current output is the last of the set
   } status_type;

endpackage

@@ hw/rtl/heap_sort_engine.sv @@
// Load: one input transaction per cycle into the element store until final_item.
// Sort: heapsort on a dual-read, single-write store; each sift-down level is a
// child read followed by a compare/write.
// Output: each result is read from the store, registered into rsp_data and held valid until rsp_ready.
// Reset (synchronous): store empty, overflow flag clear, ready to load.
module heap_sort_engine
   import hse_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   hse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hse_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

@@ hw/rtl/hse_datapath.sv @@
module hse_datapath
   import hse_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_data,
   output status_type status,
   output rsp_type    rsp_data
);

   localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int LW = IW + 2;

   // element store: one write port, two registered read ports
   logic signed [31:0] mem [MAX_ELEMENTS];
   logic [IW-1:0]      waddr;
   logic signed [31:0] wdata;
   logic               we;
   logic [IW-1:0]      raddr_a;
   logic [IW-1:0]      raddr_b;
   logic signed [31:0] rd_a_ff;
   logic signed [31:0] rd_b_ff;

   // control registers
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;

   // working registers
   logic [CW-1:0]      len_ff, len_in;
   logic [IW-1:0]      i_ff, i_in;
   logic [IW-1:0]      node_ff, node_in;
   logic [IW-1:0]      k_ff, k_in;
   logic signed [31:0] cur_ff, cur_in;
   rsp_type            rsp_ff, rsp_in;

   // child indexes and compare
   logic [LW-1:0]      left_w;
   logic [LW-1:0]      right_w;
   logic               left_ok;
   logic               right_ok;
   logic               big_left;
   logic               big_right;
   logic signed [31:0] big_val;
   logic signed [31:0] child_val;
   logic [IW-1:0]      child_idx;
   logic [IW-1:0]      i_m1;
   logic [CW-1:0]      count_m1;

   assign left_w   = {1'b0, node_ff, 1'b1};
   assign right_w  = left_w + LW'(1);
   assign left_ok  = left_w < LW'(len_ff);
   assign right_ok = right_w < LW'(len_ff);
   assign i_m1     = i_ff - IW'(1);
   assign count_m1 = count_ff - CW'(1);

   // pick the largest of node, left and right, ties stay with the earlier one
   always_comb begin
      big_left  = left_ok && (rd_a_ff > cur_ff);
      big_val   = big_left ? rd_a_ff : cur_ff;
      big_right = right_ok && (rd_b_ff > big_val);
      child_val = big_right ? rd_b_ff : rd_a_ff;
      child_idx = big_right ? right_w[IW-1:0] : left_w[IW-1:0];
   end

   // status to the controller
   always_comb begin
      status.req_final = req_data.final_item;
      status.short_set = count_ff < CW'(2);
      status.sift_more = big_left || big_right;
      status.i_one     = i_ff == IW'(1);
      status.out_last  = CW'(k_ff) == count_m1;
   end

   // memory port selection
   always_comb begin
      we      = 1'b0;
      waddr   = node_ff;
      wdata   = cur_ff;
      raddr_a = node_ff;
      raddr_b = i_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            we    = count_ff < CW'(MAX_ELEMENTS);
            waddr = count_ff[IW-1:0];
            wdata = req_data.value;
         end
         OP_SIFT: begin
            we    = 1'b1;
            waddr = node_ff;
            wdata = status.sift_more ? child_val : cur_ff;
         end
         OP_EXT_LD: begin
            we    = 1'b1;
            waddr = i_ff;
            wdata = rd_a_ff;
         end
         OP_ROOT_RD:  raddr_a = i_m1;
         OP_CHILD_RD: begin
            raddr_a = left_w[IW-1:0];
            raddr_b = right_w[IW-1:0];
         end
         OP_EXT_RD: begin
            raddr_a = '0;
            raddr_b = i_ff;
         end
         OP_OUT_RD:   raddr_a = k_ff;
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_a_ff <= mem[raddr_a];
      rd_b_ff <= mem[raddr_b];
   end

   // next values of the registers
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      len_in   = len_ff;
      i_in     = i_ff;
      node_in  = node_ff;
      k_in     = k_ff;
      cur_in   = cur_ff;
      rsp_in   = rsp_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            if (count_ff < CW'(MAX_ELEMENTS)) begin
               count_in = count_ff + CW'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         OP_SETUP: begin
            len_in = count_ff;
            i_in   = IW'(count_ff >> 1);
            k_in   = '0;
         end
         OP_ROOT_RD: node_in = i_m1;
         OP_ROOT_LD: cur_in = rd_a_ff;
         OP_SIFT: begin
            if (status.sift_more) begin
               node_in = child_idx;
            end
         end
         OP_BUILD_NEXT: begin
            i_in = status.i_one ? IW'(count_m1) : i_m1;
         end
         OP_EXT_LD: begin
            cur_in  = rd_b_ff;
            len_in  = CW'(i_ff);
            node_in = '0;
         end
         OP_EXT_NEXT: i_in = i_m1;
         OP_OUT_LD: begin
            rsp_in.sorted_value = rd_a_ff;
            rsp_in.end_of_run   = status.out_last;
            rsp_in.overflowed   = ovf_ff;
         end
         OP_OUT_NEXT: begin
            if (status.out_last) begin
               count_in = '0;
               ovf_in   = 1'b0;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      i_ff    <= i_in;
      node_ff <= node_in;
      k_ff    <= k_in;
      cur_ff  <= cur_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

@@ hw/rtl/hse_ctrl.sv @@
module hse_ctrl
   import hse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      ext_ff, ext_in;   // 1 while extracting, 0 while building the heap

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         ext_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ext_ff   <= ext_in;
      end
   end

   // next state and datapath command
   always_comb begin
      state_in  = state_ff;
      ext_in    = ext_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (status.req_final) begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            cmd.op   = OP_SETUP;
            ext_in   = 1'b0;
            state_in = status.short_set ? S_OUT_RD : S_ROOT_RD;
         end
         S_ROOT_RD: begin
            cmd.op   = OP_ROOT_RD;
            state_in = S_ROOT_LD;
         end
         S_ROOT_LD: begin
            cmd.op   = OP_ROOT_LD;
            state_in = S_CHILD_RD;
         end
         S_CHILD_RD: begin
            cmd.op   = OP_CHILD_RD;
            state_in = S_SIFT;
         end
         // one level of sift-down: move the larger child up or settle
         S_SIFT: begin
            cmd.op = OP_SIFT;
            if (status.sift_more) begin
               state_in = S_CHILD_RD;
            end else begin
               state_in = ext_ff ? S_EXT_NEXT : S_BUILD_NEXT;
            end
         end
         S_BUILD_NEXT: begin
            cmd.op = OP_BUILD_NEXT;
            if (status.i_one) begin
               ext_in   = 1'b1;
               state_in = S_EXT_RD;
            end else begin
               state_in = S_ROOT_RD;
            end
         end
         // root goes to the end of the heap, last heap entry is sifted from the top
         S_EXT_RD: begin
            cmd.op   = OP_EXT_RD;
            state_in = S_EXT_LD;
         end
         S_EXT_LD: begin
            cmd.op   = OP_EXT_LD;
            state_in = S_CHILD_RD;
         end
         S_EXT_NEXT: begin
            cmd.op   = OP_EXT_NEXT;
            state_in = status.i_one ? S_OUT_RD : S_EXT_RD;
         end
         // drain the sorted store in index order
         S_OUT_RD: begin
            cmd.op   = OP_OUT_RD;
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            cmd.op   = OP_OUT_LD;
            state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.op   = OP_OUT_NEXT;
               state_in = status.out_last ? S_LOAD : S_OUT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

@@ tb/sv/heap_sort_checker.sv @@
// Watches both channels of the sort engine, predicts the sorted output of
// each set and compares every result transaction with the oldest prediction.
module heap_sort_checker
   import hse_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      pending_results
);

   // shadow copy of the engine's element store
   logic signed [31:0] held_values [CAPACITY];
   int                 held_count;
   bit                 dropped_any;

   // sorted results still owed by the engine, oldest first
   rsp_type sorted_queue [$];

   initial begin
      mismatches      = 0;
      pending_results = 0;
      held_count      = 0;
      dropped_any     = 1'b0;
   end

   // store one element; a final element releases the whole set in order
   task automatic absorb_element(input req_type item);
      logic signed [31:0] ordered [CAPACITY];
      logic signed [31:0] pick;
      int                 j;
      rsp_type            entry;
      if (held_count < CAPACITY) begin
         held_values[held_count] = item.value;
         held_count++;
      end else begin
         // store full: element dropped, flag stays up until the set is out
         dropped_any = 1'b1;
      end
      if (item.final_item) begin
         // insertion sort, signed ascending
         for (int k = 0; k < held_count; k++) begin
            pick = held_values[k];
            j = k;
            while (j > 0 && ordered[j - 1] > pick) begin
               ordered[j] = ordered[j - 1];
               j--;
            end
            ordered[j] = pick;
         end
         for (int k = 0; k < held_count; k++) begin
            entry.sorted_value = ordered[k];
            entry.end_of_run   = (k == held_count - 1);
            entry.overflowed   = dropped_any;
            sorted_queue.push_back(entry);
         end
         held_count  = 0;
         dropped_any = 1'b0;
      end
   endtask

   // compare one result transaction against the oldest prediction
   task automatic compare_result(input rsp_type got);
      rsp_type want;
      if (sorted_queue.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected result: expected none, actual value=%0d end=%0b ovf=%0b",
                  $time, got.sorted_value, got.end_of_run, got.overflowed);
      end else begin
         want = sorted_queue.pop_front();
         if (got.sorted_value !== want.sorted_value || got.end_of_run !== want.end_of_run ||
             got.overflowed !== want.overflowed) begin
            mismatches++;
            $display("%0t: expected value=%0d end=%0b ovf=%0b, actual value=%0d end=%0b ovf=%0b",
                     $time, want.sorted_value, want.end_of_run, want.overflowed,
                     got.sorted_value, got.end_of_run, got.overflowed);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) absorb_element(req_data);
         if (rsp_valid && rsp_ready) compare_result(rsp_data);
         pending_results = sorted_queue.size();
      end
   end

endmodule

@@ tb/sv/heap_sort_engine_test.sv @@
// Drives sets of signed values into the sort engine with random gaps and
// back-pressure; the checker beside the engine does all prediction.
module heap_sort_engine_test;
   import hse_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int ITEM_TARGET = 220;
   // a full 64-element sort runs without any transaction on either channel
   localparam int STALL_LIMIT = 5000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int mismatches;
   int pending_results;
   int items_sent;
   int quiet_cycles;
   int burst_left;
   bit steady_sender;

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      items_sent    = 0;
      quiet_cycles  = 0;
      burst_left    = 0;
      steady_sender = 1'b0;
   end

   always #4 clock = ~clock;

   heap_sort_engine #(
      .MAX_ELEMENTS(CAPACITY)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   heap_sort_checker #(
      .CAPACITY(CAPACITY)
   ) scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatches     (mismatches),
      .pending_results(pending_results)
   );

   // one input transaction; called and returns at a falling edge
   task automatic send_item(input logic signed [31:0] v, input logic last);
      int      gap;
      req_type item;
      gap = steady_sender ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      item.value      = v;
      item.final_item = last;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      items_sent++;
   endtask

   // extremes and a narrow band for duplicates, otherwise full range
   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'shFFFF_FFFF;
         3: return 32'sh0000_0000;
         4, 5: return $signed($urandom_range(0, 16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_set(input int size);
      steady_sender = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < size; k++) send_item(random_value(), k == size - 1);
   endtask

   // result side: random stalls with occasional stretches of steady ready
   initial begin : result_sink
      int gap;
      while (reset) @(negedge clock);
      forever begin
         if (burst_left > 0) begin
            gap = 0;
            burst_left--;
         end else begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(5, 30);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // watchdog: too long without any transaction ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-element sets at both extremes
      send_item(32'sh7FFF_FFFF, 1'b1);
      send_item(32'sh8000_0000, 1'b1);
      // two elements, reversed
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b1);
      // mixed extremes around zero
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh0000_0000, 1'b0);
      send_item(32'shFFFF_FFFF, 1'b0);
      send_item(32'sh0000_0001, 1'b1);
      // duplicates
      send_item(3, 1'b0);
      send_item(3, 1'b0);
      send_item(-3, 1'b0);
      send_item(3, 1'b1);
      // already descending, then already ascending
      steady_sender = 1'b1;
      send_item(4, 1'b0);
      send_item(3, 1'b0);
      send_item(2, 1'b0);
      send_item(1, 1'b0);
      send_item(0, 1'b1);
      steady_sender = 1'b0;
      send_item(-2, 1'b0);
      send_item(-1, 1'b0);
      send_item(0, 1'b0);
      send_item(1, 1'b0);
      send_item(2, 1'b1);

      // exactly full, final element dropped, and a few dropped
      send_set(CAPACITY);
      send_set(CAPACITY + 1);
      send_set(CAPACITY + 3);
      while (items_sent < ITEM_TARGET) begin
         send_set(($urandom_range(0, 15) == 0) ? $urandom_range(CAPACITY - 4, CAPACITY + 6)
                                                : $urandom_range(1, 12));
      end
      req_valid <= 1'b0;

      // drain, then give a stray result time to show up
      while (pending_results != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (mismatches == 0 && pending_results == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/hse_pkg.sv
hw/rtl/hse_datapath.sv
hw/rtl/hse_ctrl.sv
hw/rtl/heap_sort_engine.sv
tb/sv/heap_sort_checker.sv
tb/sv/heap_sort_engine_test.sv
